/* rtl/qoid_pkg.sv */
// ----------------------------------------------------------------------------
// QOI decoder package
// Shared constants, types and helper functions for the QOI stream decoder.
// ----------------------------------------------------------------------------
package qoid_pkg;

    localparam int MAX_DIM_DEFAULT = 16384;
    localparam int DIM_W           = 16;
    localparam int HDR_LEN         = 14;
    localparam int MAGIC_END       = 4;
    localparam int WIDTH_END       = 8;
    localparam int HEIGHT_END      = 12;
    localparam int RUN_MAX         = 62;
    localparam int CACHE_DEPTH     = 64;
    localparam int CACHE_AW        = 6;
    localparam int PIX_DW          = 32;
    localparam int OUT_TDATA_W     = 64;
    localparam int OUT_TUSER_W     = 3;
    localparam int OUT_DIM_W       = 15;

    localparam logic [1:0] ST_PIXEL     = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_EARLY_END = 2'd3;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_RGB  = 2'd1;
    localparam logic [1:0] OP_RGBA = 2'd2;
    localparam logic [1:0] OP_LUMA = 2'd3;

    localparam logic [7:0] BYTE_RGB  = 8'hFE;
    localparam logic [7:0] BYTE_RGBA = 8'hFF;

    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pixel_t;

    typedef struct packed {
        logic                rd_en;
        logic [CACHE_AW-1:0] rd_addr;
        logic                wr_en;
        logic [CACHE_AW-1:0] wr_addr;
        pixel_t              wr_data;
    } cache_req_t;

    function automatic logic [7:0] magic_byte(logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0: m = 8'h71;
            2'd1: m = 8'h6F;
            2'd2: m = 8'h69;
            2'd3: m = 8'h66;
        endcase
        return m;
    endfunction

    function automatic logic [CACHE_AW-1:0] hash_slot(pixel_t p);
        logic [CACHE_AW-1:0] s;
        s = p.r[CACHE_AW-1:0] * 6'd3 + p.g[CACHE_AW-1:0] * 6'd5
          + p.b[CACHE_AW-1:0] * 6'd7 + p.a[CACHE_AW-1:0] * 6'd11;
        return s;
    endfunction

endpackage

/* rtl/qoid_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qoid_ram #(
    parameter int WIDTH = qoid_pkg::PIX_DW,
    parameter int DEPTH = qoid_pkg::CACHE_DEPTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/qoid_cache.sv */
// ----------------------------------------------------------------------------
// QOI color cache
// 64-entry pixel cache with per-entry valid bits and write-to-read bypass.
// ----------------------------------------------------------------------------
module qoid_cache (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qoid_pkg::cache_req_t req,
    output qoid_pkg::pixel_t     rd_pix
);

    logic [qoid_pkg::CACHE_DEPTH-1:0] valid_reg;
    logic                             rd_valid_reg;
    logic                             byp_reg;
    qoid_pkg::pixel_t                 byp_data_reg;
    logic [qoid_pkg::PIX_DW-1:0]      ram_rd_data;

    qoid_ram #(
        .WIDTH (qoid_pkg::PIX_DW),
        .DEPTH (qoid_pkg::CACHE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
                byp_reg      <= req.wr_en && (req.wr_addr == req.rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            byp_data_reg <= req.wr_data;
        end
    end

    always_comb
    begin
        if (byp_reg)
        begin
            rd_pix = byp_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_pix = qoid_pkg::pixel_t'(ram_rd_data);
        end
        else
        begin
            rd_pix = '0;
        end
    end

endmodule

/* rtl/qoid_core.sv */
// ----------------------------------------------------------------------------
// QOI decoder core
// Input byte register, header parse, op decode and pixel result register.
// ----------------------------------------------------------------------------
module qoid_core #(
    parameter int MAX_DIM = qoid_pkg::MAX_DIM_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [qoid_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [qoid_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                               m_tlast,
    output qoid_pkg::cache_req_t               cache_req,
    input  qoid_pkg::pixel_t                   cache_pix
);

    localparam int DIM_W = qoid_pkg::DIM_W;
    localparam int PIX_W = $clog2(64'(MAX_DIM) * 64'(MAX_DIM) + 64'd1);
    localparam int CNT_W = (PIX_W > 7) ? PIX_W : 7;

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic [3:0]           hdr_pos_reg,     hdr_pos_next;
    logic [DIM_W-1:0]     width_reg,       width_next;
    logic [DIM_W-1:0]     height_reg,      height_next;
    logic                 width_big_reg,   width_big_next;
    logic                 height_big_reg,  height_big_next;
    logic [PIX_W-1:0]     pixels_left_reg, pixels_left_next;
    qoid_pkg::pixel_t     cur_pix_reg,     cur_pix_next;
    logic [1:0]           pend_op_reg,     pend_op_next;
    logic [1:0]           opnd_cnt_reg,    opnd_cnt_next;
    logic [23:0]          opnd_hold_reg,   opnd_hold_next;
    logic                 error_reg;
    logic [5:0]           emit_cnt_reg;

    logic                 out_valid_reg;
    qoid_pkg::pixel_t     out_pix_reg;
    logic [qoid_pkg::OUT_DIM_W-1:0] out_width_reg;
    logic [qoid_pkg::OUT_DIM_W-1:0] out_height_reg;
    logic [1:0]           out_status_reg;
    logic                 out_ilast_reg;
    logic                 out_rlast_reg;

    logic                 s_accept;
    logic                 out_free;
    logic                 out_load;
    logic                 consume;
    logic                 hdr_phase;
    logic                 too_large;
    logic [2*DIM_W-1:0]   prod_full;
    logic                 done;
    logic [6:0]           reps;
    logic [7:0]           dg;
    qoid_pkg::pixel_t     new_pix;
    logic [CNT_W-1:0]     left_ext;
    logic [CNT_W-1:0]     reps_eff;
    logic [5:0]           pix_count;
    logic [5:0]           res_count;
    logic                 err_res;
    logic [1:0]           err_status;
    logic                 is_pix;
    logic                 res_ilast;
    logic                 res_rlast;

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign hdr_phase = hdr_pos_reg < 4'(qoid_pkg::HDR_LEN);
    assign prod_full = {{DIM_W{1'b0}}, width_reg} * {{DIM_W{1'b0}}, height_reg};
    assign too_large = width_big_reg || height_big_reg
                    || (width_reg > DIM_W'(MAX_DIM)) || (height_reg > DIM_W'(MAX_DIM));
    assign left_ext  = CNT_W'(pixels_left_reg);

    always_comb
    begin
        hdr_pos_next     = hdr_pos_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        width_big_next   = width_big_reg;
        height_big_next  = height_big_reg;
        pixels_left_next = pixels_left_reg;
        cur_pix_next     = cur_pix_reg;
        pend_op_next     = pend_op_reg;
        opnd_cnt_next    = opnd_cnt_reg;
        opnd_hold_next   = opnd_hold_reg;
        done             = 1'b0;
        reps             = 7'd1;
        dg               = 8'd0;
        new_pix          = cur_pix_reg;
        reps_eff         = '0;
        pix_count        = 6'd0;
        err_res          = 1'b0;
        err_status       = qoid_pkg::ST_EARLY_END;

        if (error_reg)
        begin
            err_res = 1'b0;
        end
        else if (hdr_phase)
        begin
            if (hdr_pos_reg < 4'(qoid_pkg::MAGIC_END))
            begin
                if (byte_reg != qoid_pkg::magic_byte(hdr_pos_reg[1:0]))
                begin
                    err_res    = 1'b1;
                    err_status = qoid_pkg::ST_BAD_MAGIC;
                end
            end
            else if (hdr_pos_reg < 4'(qoid_pkg::WIDTH_END))
            begin
                width_big_next = width_big_reg || (width_reg[DIM_W-1:DIM_W-8] != 8'd0);
                width_next     = {width_reg[DIM_W-9:0], byte_reg};
            end
            else if (hdr_pos_reg < 4'(qoid_pkg::HEIGHT_END))
            begin
                height_big_next = height_big_reg || (height_reg[DIM_W-1:DIM_W-8] != 8'd0);
                height_next     = {height_reg[DIM_W-9:0], byte_reg};
            end
            else if (hdr_pos_reg == 4'(qoid_pkg::HDR_LEN - 1))
            begin
                if (too_large)
                begin
                    err_res    = 1'b1;
                    err_status = qoid_pkg::ST_TOO_LARGE;
                end
                else
                begin
                    pixels_left_next = prod_full[PIX_W-1:0];
                end
            end
            if (!err_res)
            begin
                hdr_pos_next = hdr_pos_reg + 4'd1;
                if (last_reg && ((hdr_pos_reg != 4'(qoid_pkg::HDR_LEN - 1))
                                 || ((width_reg != '0) && (height_reg != '0))))
                begin
                    err_res = 1'b1;
                end
            end
        end
        else if (pixels_left_reg != '0)
        begin
            if ((pend_op_reg == qoid_pkg::OP_RGBA) && (opnd_cnt_reg == 2'd3))
            begin
                new_pix.r = opnd_hold_reg[23:16];
                new_pix.g = opnd_hold_reg[15:8];
                new_pix.b = opnd_hold_reg[7:0];
                new_pix.a = byte_reg;
                done      = 1'b1;
            end
            else if ((pend_op_reg == qoid_pkg::OP_RGB) || (pend_op_reg == qoid_pkg::OP_RGBA))
            begin
                opnd_hold_next = {opnd_hold_reg[15:0], byte_reg};
                opnd_cnt_next  = opnd_cnt_reg + 2'd1;
                if ((pend_op_reg == qoid_pkg::OP_RGB) && (opnd_cnt_reg == 2'd2))
                begin
                    new_pix.r = opnd_hold_reg[15:8];
                    new_pix.g = opnd_hold_reg[7:0];
                    new_pix.b = byte_reg;
                    done      = 1'b1;
                end
            end
            else if (pend_op_reg == qoid_pkg::OP_LUMA)
            begin
                dg        = {2'b00, opnd_hold_reg[5:0]} - 8'd32;
                new_pix.r = cur_pix_reg.r + dg - 8'd8 + {4'b0000, byte_reg[7:4]};
                new_pix.g = cur_pix_reg.g + dg;
                new_pix.b = cur_pix_reg.b + dg - 8'd8 + {4'b0000, byte_reg[3:0]};
                done      = 1'b1;
            end
            else if (byte_reg == qoid_pkg::BYTE_RGB)
            begin
                pend_op_next   = qoid_pkg::OP_RGB;
                opnd_cnt_next  = 2'd0;
                opnd_hold_next = '0;
            end
            else if (byte_reg == qoid_pkg::BYTE_RGBA)
            begin
                pend_op_next   = qoid_pkg::OP_RGBA;
                opnd_cnt_next  = 2'd0;
                opnd_hold_next = '0;
            end
            else
            begin
                unique case (byte_reg[7:6])
                    qoid_pkg::TAG_INDEX:
                    begin
                        new_pix = cache_pix;
                        done    = 1'b1;
                    end
                    qoid_pkg::TAG_DIFF:
                    begin
                        new_pix.r = cur_pix_reg.r + {6'd0, byte_reg[5:4]} - 8'd2;
                        new_pix.g = cur_pix_reg.g + {6'd0, byte_reg[3:2]} - 8'd2;
                        new_pix.b = cur_pix_reg.b + {6'd0, byte_reg[1:0]} - 8'd2;
                        done      = 1'b1;
                    end
                    qoid_pkg::TAG_LUMA:
                    begin
                        pend_op_next   = qoid_pkg::OP_LUMA;
                        opnd_cnt_next  = 2'd0;
                        opnd_hold_next = {16'd0, byte_reg};
                    end
                    qoid_pkg::TAG_RUN:
                    begin
                        reps = {1'b0, byte_reg[5:0]} + 7'd1;
                        done = 1'b1;
                    end
                endcase
            end

            if (done)
            begin
                pend_op_next   = qoid_pkg::OP_NONE;
                opnd_cnt_next  = 2'd0;
                opnd_hold_next = '0;
                cur_pix_next   = new_pix;
                reps_eff       = (CNT_W'(reps) > left_ext) ? left_ext : CNT_W'(reps);
                if (last_reg && (reps_eff == CNT_W'(qoid_pkg::RUN_MAX)) && (left_ext > reps_eff))
                begin
                    reps_eff = CNT_W'(qoid_pkg::RUN_MAX - 1);
                end
                pix_count        = reps_eff[5:0];
                pixels_left_next = PIX_W'(left_ext - reps_eff);
                err_res          = last_reg && (left_ext > reps_eff);
            end
            else
            begin
                err_res = last_reg;
            end
        end
        res_count = pix_count + 6'(err_res);
    end

    assign is_pix    = emit_cnt_reg < pix_count;
    assign res_ilast = is_pix && (left_ext == (CNT_W'(emit_cnt_reg) + CNT_W'(1)));
    assign res_rlast = emit_cnt_reg == (res_count - 6'd1);
    assign out_load  = in_valid_reg && (res_count != 6'd0) && out_free;
    assign consume   = in_valid_reg && ((res_count == 6'd0) || (out_free && res_rlast));
    assign s_tready  = !in_valid_reg || consume;

    assign cache_req.rd_en   = s_accept;
    assign cache_req.rd_addr = s_tdata[qoid_pkg::CACHE_AW-1:0];
    assign cache_req.wr_en   = consume && done;
    assign cache_req.wr_addr = qoid_pkg::hash_slot(new_pix);
    assign cache_req.wr_data = new_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            hdr_pos_reg     <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            width_big_reg   <= 1'b0;
            height_big_reg  <= 1'b0;
            pixels_left_reg <= '0;
            cur_pix_reg     <= '{a: 8'hFF, b: 8'h00, g: 8'h00, r: 8'h00};
            pend_op_reg     <= qoid_pkg::OP_NONE;
            opnd_cnt_reg    <= '0;
            opnd_hold_reg   <= '0;
            error_reg       <= 1'b0;
            emit_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end

            if (consume)
            begin
                emit_cnt_reg    <= '0;
                hdr_pos_reg     <= hdr_pos_next;
                width_reg       <= width_next;
                height_reg      <= height_next;
                width_big_reg   <= width_big_next;
                height_big_reg  <= height_big_next;
                pixels_left_reg <= pixels_left_next;
                cur_pix_reg     <= cur_pix_next;
                pend_op_reg     <= pend_op_next;
                opnd_cnt_reg    <= opnd_cnt_next;
                opnd_hold_reg   <= opnd_hold_next;
                error_reg       <= error_reg || err_res;
            end
            else if (out_load)
            begin
                emit_cnt_reg <= emit_cnt_reg + 6'd1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (out_load)
        begin
            out_pix_reg    <= is_pix ? new_pix : '0;
            out_width_reg  <= width_next[qoid_pkg::OUT_DIM_W-1:0];
            out_height_reg <= height_next[qoid_pkg::OUT_DIM_W-1:0];
            out_status_reg <= is_pix ? qoid_pkg::ST_PIXEL : err_status;
            out_ilast_reg  <= res_ilast;
            out_rlast_reg  <= res_rlast;
        end
    end

    // tdata: blue, green, red, alpha, image_width, image_height, zero fill
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_height_reg, out_width_reg,
                       out_pix_reg.a, out_pix_reg.r, out_pix_reg.g, out_pix_reg.b};
    // tuser: status, run_last
    assign m_tuser  = {out_rlast_reg, out_status_reg};
    assign m_tlast  = out_ilast_reg;

`ifndef SYNTHESIS
    a_quiet_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> !out_load)
        else $error("result produced after error");

    a_image_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_ilast) |=> (pixels_left_reg == '0))
        else $error("final pixel left pixels outstanding");

    a_header_no_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_pos_reg < 4'(qoid_pkg::HDR_LEN)) |-> (pixels_left_reg == '0))
        else $error("pixel count set before header complete");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> ((emit_cnt_reg == 6'd0) || (emit_cnt_reg < res_count)))
        else $error("result index beyond result count");
`endif

endmodule

/* rtl/qoi_image_stream_decoder.sv */
// ----------------------------------------------------------------------------
// QOI image stream decoder
// Byte-serial QOI decoder producing BGRA pixels with header sizes and status.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the QOI file one byte per transaction on the s_ channel, header
//   first, with s_tlast on the final byte. Pixels leave on the m_ channel,
//   one per transaction, with m_tlast on the final pixel of the image and
//   m_tuser carrying the status code and the last-result-of-byte flag.
//   A bad magic, an oversize image or a stream that ends early yields one
//   error transaction; all later bytes are dropped until reset.
// Flow:
//   A byte is held in the input register until its results have gone to
//   the single result register; one byte is taken per cycle while nothing
//   stalls. A RUN byte of N pixels gives N results, one per pixel. Bytes
//   that give no result are retired without waiting on the output.
// Reset:
//   rst_n clears the parser, the current pixel (opaque black) and the valid
//   bits of the 64-entry color cache at once; no clearing pass is needed.
// Stall:
//   When m_tready is low the result register holds and the input stalls
//   once the byte in flight has a result waiting.
// ----------------------------------------------------------------------------
module qoi_image_stream_decoder #(
    parameter int MAX_DIM = qoid_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [qoid_pkg::OUT_TDATA_W-1:0] m_tdata,   // blue, green, red, alpha,
                                                        // image_width, image_height
    output logic [qoid_pkg::OUT_TUSER_W-1:0] m_tuser,   // status, run_last
    output logic                             m_tlast
);

    qoid_pkg::cache_req_t cache_req;
    qoid_pkg::pixel_t     cache_pix;

    qoid_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cache_req (cache_req),
        .cache_pix (cache_pix)
    );

    qoid_cache u_cache (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (cache_req),
        .rd_pix (cache_pix)
    );

endmodule
